FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the quadrature counter core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define QCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qcc assertion failed (same cycle)");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define QCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qcc assertion failed (next cycle)");

`endif

FILE: design/qcc_pkg.sv
// ----------------------------------------------------------------------------
// qcc_pkg
// types and constants for the four channel x4 quadrature counter core
// ----------------------------------------------------------------------------
package qcc_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int COUNT_WIDTH  = 16;
   localparam int PAIR_WIDTH   = 2;
   localparam int SAMPLE_WIDTH = NUM_CHANNELS * PAIR_WIDTH;
   localparam int INDEX_WIDTH  = 2 * PAIR_WIDTH;

   typedef logic [PAIR_WIDTH-1:0]   pair_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [INDEX_WIDTH-1:0]  index_type;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_UP,
      STEP_DOWN,
      STEP_SLIP
   } step_type;

   // status of one channel lane towards the result register
   typedef struct packed {
      count_type count_next;
      logic      slip;
   } lane_status_type;

   // gray code step per index of new pair above previous pair
   localparam step_type STEP_TABLE [16] = '{
      STEP_HOLD, STEP_DOWN, STEP_UP,   STEP_SLIP,
      STEP_UP,   STEP_HOLD, STEP_SLIP, STEP_DOWN,
      STEP_DOWN, STEP_SLIP, STEP_HOLD, STEP_UP,
      STEP_SLIP, STEP_UP,   STEP_DOWN, STEP_HOLD
   };

endpackage

FILE: design/qcc_if.sv
// ----------------------------------------------------------------------------
// qcc_req_if / qcc_rsp_if
// valid/ready channels for pin samples and counter results
// ----------------------------------------------------------------------------
interface qcc_req_if import qcc_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type pin_sample;

   modport source (output valid, output pin_sample, input ready);
   modport sink (input valid, input pin_sample, output ready);
endinterface

interface qcc_rsp_if import qcc_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type count_a;
   count_type count_b;
   count_type count_c;
   count_type count_d;
   logic      slip_seen;

   modport source (output valid, output count_a, output count_b, output count_c,
                   output count_d, output slip_seen, input ready);
   modport sink (input valid, input count_a, input count_b, input count_c,
                 input count_d, input slip_seen, output ready);
endinterface

FILE: design/quad_channel_quadrature_counter_core.sv
// ----------------------------------------------------------------------------
// quad_channel_quadrature_counter_core
// four channel x4 quadrature decoder with wrapping position counters
// ----------------------------------------------------------------------------
// Each request is one 8-bit sample of four A/B pin pairs, channel k on bits
// 2k+1:2k. The sample is registered, decoded against each channel's previous
// pair, and the four 16-bit counters plus the slip flag move on to a result
// register once it is free or read. One request is taken every clock while
// req.ready is high; the input register keeps accepting while a result
// waits, so a stalled sink costs at most one further sample before req.ready
// drops. A slip (both pins of a pair changed) holds that counter and sets
// slip_seen. After reset all counters and stored pairs are zero.
`include "assert_macros.svh"

module quad_channel_quadrature_counter_core import qcc_pkg::*; (
   input logic   clock,
   input logic   reset,
   qcc_req_if.sink   req,
   qcc_rsp_if.source rsp
);

   logic            in_valid_ff;
   sample_type      sample_ff;
   logic            out_valid_ff;
   count_type       counts_ff [NUM_CHANNELS];
   logic            slip_ff;
   logic            advance;
   logic            slip_any;
   logic            out_stall;
   logic            stage_held;
   lane_status_type lane_status [NUM_CHANNELS];

   assign advance = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         sample_ff <= req.pin_sample;
      end
   end

   for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
      qcc_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .pair    (sample_ff[ch*PAIR_WIDTH +: PAIR_WIDTH]),
         .status  (lane_status[ch])
      );
   end

   always_comb begin
      slip_any = 1'b0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         slip_any = slip_any | lane_status[ch].slip;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            counts_ff[ch] <= lane_status[ch].count_next;
         end
         slip_ff <= slip_any;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.count_a   = counts_ff[0];
   assign rsp.count_b   = counts_ff[1];
   assign rsp.count_c   = counts_ff[2];
   assign rsp.count_d   = counts_ff[3];
   assign rsp.slip_seen = slip_ff;

   // assertions
   assign out_stall  = out_valid_ff && !rsp.ready;
   assign stage_held = in_valid_ff && out_stall;

   `QCC_ASSERT_NEXT(a_stage_held, clock, reset, stage_held, in_valid_ff && $stable(sample_ff))
   `QCC_ASSERT_NEXT(a_result_follows, clock, reset, advance, out_valid_ff)
   `QCC_ASSERT_NEXT(a_result_drains, clock, reset, out_valid_ff && rsp.ready && !advance, !out_valid_ff)
   `QCC_ASSERT_IMPLY(a_no_overwrite, clock, reset, out_stall, !advance)

endmodule

FILE: design/qcc_lane.sv
// ----------------------------------------------------------------------------
// qcc_lane
// one encoder channel: previous pair, step decode and wrapping counter
// ----------------------------------------------------------------------------
module qcc_lane import qcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  pair_type        pair,
   output lane_status_type status
);

   pair_type  prev_ff;
   pair_type  prev_in;
   count_type count_ff;
   count_type count_in;
   index_type index;
   step_type  step;

   always_comb begin
      index = {pair, prev_ff};
      step  = STEP_TABLE[index];
      case (step)
         STEP_UP:   count_in = count_ff + count_type'(1);
         STEP_DOWN: count_in = count_ff - count_type'(1);
         default:   count_in = count_ff;
      endcase
      prev_in           = pair;
      status.count_next = count_in;
      status.slip       = (step == STEP_SLIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else if (advance) begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

endmodule
